// ===== rtl/core/abp_pkg.sv =====
// Shared types and constants for the alternating-bit endpoint.
// Holds word layouts, function and kind codes, register map and queue sizing.
// No dependencies.
package abp_pkg;

  // Byte queue sizing
  localparam int QUEUE_DEPTH = 64;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  // Result buffer sizing
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int RES_CW    = $clog2(RES_DEPTH + 1);

  // Field widths
  localparam int ADDR_W = 48;
  localparam int BYTE_W = 8;
  localparam int CODE_W = 3;
  localparam int RTRY_W = 8;
  localparam int TICK_W = 16;

  // Configuration port
  localparam int CFG_DW = 64;
  localparam int CFG_AW = 5;

  localparam logic [RTRY_W-1:0] RETRY_LIMIT_RST   = 8'd3;
  localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd15;

  typedef enum logic [1:0] {
    REG_DEST_ADDR     = 2'd0,
    REG_RETRY_LIMIT   = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } reg_idx_t;

  typedef enum logic [CODE_W-1:0] {
    FN_USER_BYTE = 3'd0,
    FN_USER_ACK  = 3'd1,
    FN_PEER_DATA = 3'd2,
    FN_PEER_ACK  = 3'd3,
    FN_TICK      = 3'd4
  } func_t;

  typedef enum logic [CODE_W-1:0] {
    KIND_DATA_PEER = 3'd0,
    KIND_ACK_PEER  = 3'd1,
    KIND_DATA_USER = 3'd2,
    KIND_ACK_USER  = 3'd3,
    KIND_DROPPED   = 3'd4
  } kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] func;
    logic [BYTE_W-1:0] data_byte;
    logic              bit_flag;
    logic [ADDR_W-1:0] peer_addr;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] kind;
    logic [ADDR_W-1:0] addr_out;
    logic [BYTE_W-1:0] payload;
    logic              bit_out;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest_addr;
    logic [RTRY_W-1:0] retry_limit;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_regs_t;

  // Control toward the byte queue
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              flush;
    logic [BYTE_W-1:0] push_data;
  } q_cmd_t;

  // Status from the byte queue
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [BYTE_W-1:0] head_data;
  } q_stat_t;

  // Up to two results written into the result buffer per item
  typedef struct packed {
    logic      push0;
    logic      push1;
    out_word_t res0;
    out_word_t res1;
  } res_push_t;

endpackage

// ===== rtl/core/abp_cfg.sv =====
// Configuration register file with an APB-style access port.
// Depends on abp_pkg for the register map and reset values.
module abp_cfg import abp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_regs_t         regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign wr_en = psel && penable && pwrite;
  assign regs  = regs_r;

  // Decode the write
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (idx)
        REG_DEST_ADDR:     regs_nxt.dest_addr     = pwdata[ADDR_W-1:0];
        REG_RETRY_LIMIT:   regs_nxt.retry_limit   = pwdata[RTRY_W-1:0];
        REG_TIMEOUT_TICKS: regs_nxt.timeout_ticks = pwdata[TICK_W-1:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.dest_addr     <= '0;
      regs_r.retry_limit   <= RETRY_LIMIT_RST;
      regs_r.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_DEST_ADDR:     prdata = CFG_DW'(regs_r.dest_addr);
      REG_RETRY_LIMIT:   prdata = CFG_DW'(regs_r.retry_limit);
      REG_TIMEOUT_TICKS: prdata = CFG_DW'(regs_r.timeout_ticks);
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/abp_queue.sv =====
// Byte queue: synchronous memory with head, tail and fill count.
// The next head entry is read every cycle, with a write-to-read bypass.
// Depends on abp_pkg for sizing and the command and status structs.
module abp_queue import abp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_cmd_t  cmd,
  output q_stat_t stat
);

  logic [BYTE_W-1:0] mem [QUEUE_DEPTH];

  logic [Q_AW-1:0]   head_r, head_nxt;
  logic [Q_AW-1:0]   tail_r, tail_nxt;
  logic [Q_CW-1:0]   count_r, count_nxt;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] byp_data_r;
  logic              byp_r;

  function automatic logic [Q_AW-1:0] wrap_inc(input logic [Q_AW-1:0] x);
    return (x == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  // Advance pointers and fill count
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.flush) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.push) begin
      tail_nxt  = wrap_inc(tail_r);
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      head_nxt  = wrap_inc(head_r);
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      byp_r   <= cmd.push && (tail_r == head_nxt);
    end
  end

  // Write at tail, read the upcoming head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= cmd.push_data;
    end
    rdata_r    <= mem[head_nxt];
    byp_data_r <= cmd.push_data;
  end

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == Q_CW'(QUEUE_DEPTH));
  assign stat.head_data = byp_r ? byp_data_r : rdata_r;

endmodule

// ===== rtl/core/abp_resq.sv =====
// Result buffer: small register FIFO taking up to two words per cycle.
// Drives the output channel. Depends on abp_pkg for sizing and word types.
module abp_resq import abp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t push,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  out_word_t         ent_r [RES_DEPTH];
  logic [RES_AW-1:0] wp_r, rp_r;
  logic [RES_CW-1:0] cnt_r, cnt_nxt;
  logic [RES_AW-1:0] wp_nxt;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = ent_r[rp_r];
  assign room2     = (cnt_r <= RES_CW'(RES_DEPTH - 2));
  assign wp_nxt    = wp_r + RES_AW'(push.push0) + RES_AW'(push.push1);

  always_comb begin
    cnt_nxt = cnt_r + RES_CW'(push.push0) + RES_CW'(push.push1) - RES_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_r + RES_AW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  // Store new words in order
  always_ff @(posedge clk) begin
    if (push.push0) begin
      ent_r[wp_r] <= push.res0;
    end
    if (push.push1) begin
      ent_r[wp_r + 1'b1] <= push.res1;
    end
  end

endmodule

// ===== rtl/core/abp_ctrl.sv =====
// Protocol control: endpoint state, tick timer and result formation.
// Drives the byte queue and the result buffer. Depends on abp_pkg.
module abp_ctrl import abp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_word_t  in_word,
  input  cfg_regs_t regs,
  input  q_stat_t   q_stat,
  output q_cmd_t    q_cmd,
  output res_push_t res_push,
  output logic      waiting
);

  logic              waiting_r, waiting_nxt;
  logic              alt_bit_r, alt_bit_nxt;
  logic [RTRY_W-1:0] retry_r, retry_nxt;
  logic [BYTE_W-1:0] last_sent_r, last_sent_nxt;
  logic [TICK_W-1:0] timer_r, timer_nxt;
  logic              running_r, running_nxt;

  logic [TICK_W-1:0] timer_inc;
  logic [RTRY_W:0]   retry_inc;

  assign timer_inc = timer_r + 1'b1;
  assign retry_inc = {1'b0, retry_r} + 1'b1;
  assign waiting   = waiting_r;

  // Decode one word and update state
  always_comb begin
    waiting_nxt   = waiting_r;
    alt_bit_nxt   = alt_bit_r;
    retry_nxt     = retry_r;
    last_sent_nxt = last_sent_r;
    timer_nxt     = timer_r;
    running_nxt   = running_r;
    q_cmd         = '0;
    q_cmd.push_data = in_word.data_byte;
    res_push      = '0;
    if (fire) begin
      unique case (func_t'(in_word.func))
        FN_USER_BYTE: begin
          if (!waiting_r) begin
            waiting_nxt   = 1'b1;
            alt_bit_nxt   = 1'b0;
            retry_nxt     = '0;
            last_sent_nxt = in_word.data_byte;
            timer_nxt     = '0;
            running_nxt   = 1'b1;
            res_push.push0 = 1'b1;
            res_push.res0  = '{KIND_DATA_PEER, regs.dest_addr, in_word.data_byte,
                               1'b0, 1'b1};
          end else if (q_stat.full) begin
            res_push.push0 = 1'b1;
            res_push.res0  = '{KIND_DROPPED, '0, in_word.data_byte, 1'b0, 1'b1};
          end else begin
            q_cmd.push = 1'b1;
          end
        end
        FN_USER_ACK: begin
          res_push.push0 = 1'b1;
          res_push.res0  = '{KIND_ACK_PEER, regs.dest_addr, '0, in_word.bit_flag, 1'b1};
        end
        FN_PEER_DATA: begin
          res_push.push0 = 1'b1;
          res_push.res0  = '{KIND_DATA_USER, in_word.peer_addr, in_word.data_byte,
                             in_word.bit_flag, 1'b1};
        end
        FN_PEER_ACK: begin
          if (waiting_r) begin
            res_push.push0 = 1'b1;
            if (in_word.bit_flag != alt_bit_r) begin
              // Stale ACK: report only
              res_push.res0 = '{KIND_ACK_USER, '0, '0, in_word.bit_flag, 1'b1};
            end else begin
              res_push.res0  = '{KIND_ACK_USER, '0, '0, in_word.bit_flag, 1'b0};
              res_push.push1 = 1'b1;
              retry_nxt      = '0;
              if (q_stat.empty) begin
                // Send end of transfer and drop back to idle
                res_push.res1 = '{KIND_DATA_PEER, regs.dest_addr, '0, ~alt_bit_r, 1'b1};
                last_sent_nxt = '0;
                waiting_nxt   = 1'b0;
                alt_bit_nxt   = 1'b0;
                timer_nxt     = '0;
                running_nxt   = 1'b0;
              end else begin
                q_cmd.pop     = 1'b1;
                res_push.res1 = '{KIND_DATA_PEER, regs.dest_addr, q_stat.head_data,
                                  ~alt_bit_r, 1'b1};
                last_sent_nxt = q_stat.head_data;
                alt_bit_nxt   = ~alt_bit_r;
                timer_nxt     = '0;
                running_nxt   = 1'b1;
              end
            end
          end
        end
        FN_TICK: begin
          if (waiting_r && running_r) begin
            timer_nxt = timer_inc;
            if (timer_inc >= regs.timeout_ticks) begin
              running_nxt = 1'b0;
              if (retry_inc > {1'b0, regs.retry_limit}) begin
                // Give up: flush and go idle silently
                q_cmd.flush = 1'b1;
                waiting_nxt = 1'b0;
                alt_bit_nxt = 1'b0;
                retry_nxt   = '0;
                timer_nxt   = '0;
              end else begin
                retry_nxt      = retry_inc[RTRY_W-1:0];
                timer_nxt      = '0;
                running_nxt    = 1'b1;
                res_push.push0 = 1'b1;
                res_push.res0  = '{KIND_DATA_PEER, regs.dest_addr, last_sent_r,
                                   alt_bit_r, 1'b1};
              end
            end
          end
        end
        default: begin
          // Unknown function: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= 1'b0;
      alt_bit_r   <= 1'b0;
      retry_r     <= '0;
      last_sent_r <= '0;
      timer_r     <= '0;
      running_r   <= 1'b0;
    end else begin
      waiting_r   <= waiting_nxt;
      alt_bit_r   <= alt_bit_nxt;
      retry_r     <= retry_nxt;
      last_sent_r <= last_sent_nxt;
      timer_r     <= timer_nxt;
      running_r   <= running_nxt;
    end
  end

endmodule

// ===== rtl/core/alternating_bit_endpoint.sv =====
// Stop-and-wait alternating-bit endpoint. One input word is taken per clock
// whenever the four-word result buffer has room for two words; the protocol
// state and the byte queue update at that same edge. An ACK that releases the
// next byte yields two result words, so the sustained rate is set by the
// output port. The byte queue is a single-port-write synchronous memory whose
// next head entry is read every cycle with a bypass from the same-cycle
// write, so a dequeue never has to wait for the memory read. The queue
// needs no clearing pass after reset. Configuration registers sit at byte
// addresses 0, 8 and 16 of the port.
module alternating_bit_endpoint import abp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_regs_t regs;
  q_cmd_t    q_cmd;
  q_stat_t   q_stat;
  res_push_t res_push;
  logic      room2;
  logic      fire;
  logic      waiting;

  assign cfg_pready = 1'b1;
  assign in_ready   = room2;
  assign fire       = in_valid && in_ready;

  abp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .regs    (regs)
  );

  abp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q_cmd),
    .stat  (q_stat)
  );

  abp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_word  (in_data),
    .regs     (regs),
    .q_stat   (q_stat),
    .q_cmd    (q_cmd),
    .res_push (res_push),
    .waiting  (waiting)
  );

  abp_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Never enqueue into a full queue, never dequeue from an empty one
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_cmd.push |-> !q_stat.full)
    else $error("byte queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_cmd.pop |-> (!q_stat.empty && waiting))
    else $error("byte queue read while empty or idle");

  // A second result only follows a first one, and only a matched ACK is non-final
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    res_push.push1 |-> (res_push.push0 && !res_push.res0.last &&
                        res_push.res1.kind == KIND_DATA_PEER))
    else $error("result pair out of order");

  a_nonfinal_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (out_data.kind == KIND_ACK_USER))
    else $error("non-final word is not a user ack");

endmodule

// ===== test/abp_endpoint_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the alternating-bit endpoint: mirrors protocol state from
// accepted input words and register writes, and checks each result word in order.
// Depends on abp_pkg for word layouts, codes and sizing.
module abp_endpoint_checker import abp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_word_t          in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_word_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic [CFG_DW-1:0] cfg_prdata,
  output int                due_count,
  output int                mismatch_count
);

  // Register copies
  logic [ADDR_W-1:0] dest_addr;
  logic [RTRY_W-1:0] retry_limit;
  logic [TICK_W-1:0] tick_limit;

  // Protocol state
  logic              sending;
  logic              seq_bit;
  logic [RTRY_W-1:0] resends;
  logic [BYTE_W-1:0] last_byte;
  logic [BYTE_W-1:0] backlog [QUEUE_DEPTH];
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_CW-1:0]   backlog_cnt;
  logic [TICK_W-1:0] ticks;
  logic              timer_on;
  logic [CFG_DW-1:0] reg_readback;

  // Result words owed by the endpoint, oldest first
  out_word_t due_msgs[$];

  function automatic out_word_t make_msg(kind_t kind, logic [ADDR_W-1:0] addr,
                                         logic [BYTE_W-1:0] payload, logic flag,
                                         logic last);
    out_word_t m;
    m.kind     = kind;
    m.addr_out = addr;
    m.payload  = payload;
    m.bit_out  = flag;
    m.last     = last;
    return m;
  endfunction

  function automatic logic [Q_AW-1:0] bump(logic [Q_AW-1:0] i);
    return (i == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Send a byte to the peer and restart the one-shot timer
  task automatic send_byte(logic [BYTE_W-1:0] b);
    last_byte = b;
    ticks     = '0;
    timer_on  = 1'b1;
    due_msgs.push_back(make_msg(KIND_DATA_PEER, dest_addr, b, seq_bit, 1'b1));
  endtask

  task automatic drop_to_idle();
    sending  = 1'b0;
    seq_bit  = 1'b0;
    resends  = '0;
    timer_on = 1'b0;
    ticks    = '0;
  endtask

  task automatic clear_state();
    dest_addr   = '0;
    retry_limit = RETRY_LIMIT_RST;
    tick_limit  = TIMEOUT_TICKS_RST;
    drop_to_idle();
    last_byte   = '0;
    rd_ptr      = '0;
    wr_ptr      = '0;
    backlog_cnt = '0;
    due_msgs.delete();
  endtask

  // Advance the protocol by one accepted word and queue what it owes
  task automatic advance_endpoint(in_word_t w);
    logic [RTRY_W:0]   next_try;
    logic [BYTE_W-1:0] head;
    case (w.func)
      FN_USER_BYTE: begin
        if (!sending) begin
          seq_bit = 1'b0;
          resends = '0;
          sending = 1'b1;
          send_byte(w.data_byte);
        end else if (backlog_cnt >= Q_CW'(QUEUE_DEPTH)) begin
          due_msgs.push_back(make_msg(KIND_DROPPED, '0, w.data_byte, 1'b0, 1'b1));
        end else begin
          backlog[wr_ptr] = w.data_byte;
          wr_ptr          = bump(wr_ptr);
          backlog_cnt     = backlog_cnt + 1'b1;
        end
      end
      FN_USER_ACK: begin
        due_msgs.push_back(make_msg(KIND_ACK_PEER, dest_addr, '0, w.bit_flag, 1'b1));
      end
      FN_PEER_DATA: begin
        due_msgs.push_back(make_msg(KIND_DATA_USER, w.peer_addr, w.data_byte,
                                    w.bit_flag, 1'b1));
      end
      FN_PEER_ACK: begin
        if (sending) begin
          if (w.bit_flag != seq_bit) begin
            // stale ack: report only
            due_msgs.push_back(make_msg(KIND_ACK_USER, '0, '0, w.bit_flag, 1'b1));
          end else begin
            due_msgs.push_back(make_msg(KIND_ACK_USER, '0, '0, w.bit_flag, 1'b0));
            seq_bit = ~seq_bit;
            resends = '0;
            if (backlog_cnt == '0) begin
              // empty queue: close with an end-of-transfer byte
              send_byte('0);
              drop_to_idle();
            end else begin
              head        = backlog[rd_ptr];
              rd_ptr      = bump(rd_ptr);
              backlog_cnt = backlog_cnt - 1'b1;
              send_byte(head);
            end
          end
        end
      end
      FN_TICK: begin
        if (sending && timer_on) begin
          ticks = ticks + 1'b1;
          if (ticks >= tick_limit) begin
            timer_on = 1'b0;
            next_try = {1'b0, resends} + 1'b1;
            if (next_try > {1'b0, retry_limit}) begin
              // give up: flush the queue silently
              rd_ptr      = '0;
              wr_ptr      = '0;
              backlog_cnt = '0;
              drop_to_idle();
            end else begin
              resends = next_try[RTRY_W-1:0];
              send_byte(last_byte);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // Compare one result word against the oldest one owed
  task automatic check_msg(out_word_t got);
    out_word_t want;
    if (due_msgs.size() == 0) begin
      $error("unexpected result word: kind %0d addr_out %0h payload %0h",
             got.kind, got.addr_out, got.payload);
      mismatch_count++;
    end else begin
      want = due_msgs.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        mismatch_count++;
      end
      if (got.addr_out !== want.addr_out) begin
        $error("addr_out: expected %0h, actual %0h", want.addr_out, got.addr_out);
        mismatch_count++;
      end
      if (got.payload !== want.payload) begin
        $error("payload: expected %0h, actual %0h", want.payload, got.payload);
        mismatch_count++;
      end
      if (got.bit_out !== want.bit_out) begin
        $error("bit_out: expected %0b, actual %0b", want.bit_out, got.bit_out);
        mismatch_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        mismatch_count++;
      end
    end
  endtask

  // Retire results before predicting: a word accepted now cannot answer yet
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (out_valid && out_ready) check_msg(out_data);
      if (in_valid && in_ready) advance_endpoint(in_data);
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[CFG_AW-1:3])
            REG_DEST_ADDR:     dest_addr   = cfg_pwdata[ADDR_W-1:0];
            REG_RETRY_LIMIT:   retry_limit = cfg_pwdata[RTRY_W-1:0];
            REG_TIMEOUT_TICKS: tick_limit  = cfg_pwdata[TICK_W-1:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr[CFG_AW-1:3])
            REG_DEST_ADDR:     reg_readback = CFG_DW'(dest_addr);
            REG_RETRY_LIMIT:   reg_readback = CFG_DW'(retry_limit);
            REG_TIMEOUT_TICKS: reg_readback = CFG_DW'(tick_limit);
            default:           reg_readback = '0;
          endcase
          if (cfg_prdata !== reg_readback) begin
            $error("prdata: expected %0h, actual %0h", reg_readback, cfg_prdata);
            mismatch_count++;
          end
        end
      end
    end
    due_count = due_msgs.size();
  end

endmodule

// ===== test/alternating_bit_endpoint_tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the alternating-bit endpoint: directed corner words,
// then register phases of random transfers. Depends on abp_pkg and abp_endpoint_checker.
module alternating_bit_endpoint_tb;
  import abp_pkg::*;

  localparam int WORD_TARGET   = 1850;
  localparam int PHASES        = 6;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 8;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  int                due_count;
  int                mismatch_count;

  int words_sent;
  bit tx_gaps;
  bit rx_gaps;
  int hold_reqs;

  alternating_bit_endpoint dut (.*);

  abp_endpoint_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_W-1:0];
  endfunction

  function automatic in_word_t word_of(logic [CODE_W-1:0] f, logic [BYTE_W-1:0] b,
                                       logic flag, logic [ADDR_W-1:0] addr);
    in_word_t w;
    w.func      = f;
    w.data_byte = b;
    w.bit_flag  = flag;
    w.peer_addr = addr;
    return w;
  endfunction

  function automatic in_word_t rand_word(logic [CODE_W-1:0] f);
    return word_of(f, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   rand_addr());
  endfunction

  // Offer one word, optionally after a gap, and hold it until accepted
  task automatic push_word(in_word_t w);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (w.func <= FN_TICK) words_sent++;
  endtask

  // Pause the sender until every owed result has come, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(bit wr, reg_idx_t idx, logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_AW'({idx, 3'b000});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write one set of register values per phase and read each back
  task automatic program_regs(int p);
    logic [ADDR_W-1:0] dest;
    logic [RTRY_W-1:0] tries;
    logic [TICK_W-1:0] tmo;
    dest = rand_addr();
    case (p)
      0: begin
        dest  = '1;
        tries = '0;
        tmo   = 16'd1;
      end
      1: begin
        tries = 8'd2;
        tmo   = 16'd4;
      end
      2: begin
        dest  = '0;
        tries = '1;
        tmo   = '0;
      end
      3: begin
        tries = 8'd5;
        tmo   = '1;
      end
      4: begin
        tries = 8'd1;
        tmo   = 16'd2;
      end
      default: begin
        tries = RETRY_LIMIT_RST;
        tmo   = TIMEOUT_TICKS_RST;
      end
    endcase
    apb_access(1'b1, REG_DEST_ADDR, CFG_DW'(dest));
    apb_access(1'b1, REG_RETRY_LIMIT, CFG_DW'(tries));
    apb_access(1'b1, REG_TIMEOUT_TICKS, CFG_DW'(tmo));
    apb_access(1'b0, REG_DEST_ADDR, '0);
    apb_access(1'b0, REG_RETRY_LIMIT, '0);
    apb_access(1'b0, REG_TIMEOUT_TICKS, '0);
  endtask

  // One transfer: a burst of user bytes, then acks, ticks and side traffic
  task automatic run_transfer(bit quiet);
    int nbytes;
    int nsteps;
    int pick;
    tx_gaps = !quiet && ($urandom_range(0, 3) != 0);
    rx_gaps = !quiet && ($urandom_range(0, 3) != 0);
    nbytes  = ($urandom_range(0, 11) == 0) ? $urandom_range(64, 70) : $urandom_range(1, 8);
    nsteps  = nbytes + $urandom_range(2, 8);
    repeat (nbytes) push_word(rand_word(FN_USER_BYTE));
    repeat (nsteps) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_word(rand_word(FN_PEER_ACK));
      end else if (pick < 70) begin
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
          push_word(rand_word(FN_TICK));
      end else if (pick < 80) begin
        push_word(rand_word(FN_PEER_DATA));
      end else if (pick < 88) begin
        push_word(rand_word(FN_USER_ACK));
      end else if (pick < 95) begin
        push_word(rand_word(FN_USER_BYTE));
      end else begin
        push_word(rand_word(CODE_W'($urandom_range(FN_TICK + 1, 7))));
      end
    end
  endtask

  // Corner words under reset register values
  task automatic run_directed();
    push_word(word_of(FN_PEER_ACK, 8'h00, 1'b1, '0));      // ack while idle
    push_word(word_of(FN_TICK, 8'h00, 1'b0, '0));          // tick while idle
    for (int f = FN_TICK + 1; f < 8; f++) push_word(rand_word(CODE_W'(f)));
    push_word(word_of(FN_USER_ACK, 8'h00, 1'b0, '0));
    push_word(word_of(FN_USER_ACK, 8'hFF, 1'b1, '1));
    push_word(word_of(FN_PEER_DATA, 8'hFF, 1'b1, '1));
    push_word(word_of(FN_PEER_DATA, 8'h00, 1'b0, '0));
    push_word(word_of(FN_USER_BYTE, 8'hFF, 1'b0, '0));     // sent at once
    push_word(word_of(FN_USER_BYTE, 8'h00, 1'b1, '1));     // queued
    push_word(word_of(FN_USER_BYTE, 8'hA5, 1'b0, '0));     // queued
    push_word(word_of(FN_PEER_ACK, 8'h00, 1'b1, '0));      // stale ack
    push_word(word_of(FN_PEER_ACK, 8'h00, 1'b0, '0));      // release next byte
    push_word(word_of(FN_PEER_ACK, 8'h00, 1'b1, '0));
    push_word(word_of(FN_PEER_ACK, 8'h00, 1'b0, '0));      // empty queue, end of transfer
    push_word(word_of(FN_USER_BYTE, 8'h3C, 1'b1, '1));     // leave it waiting
  endtask

  // Receiver: random stall bursts, plus one long hold-off per request
  initial begin
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_reqs != holds_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Sender and verdict
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    words_sent  = 0;
    tx_gaps     = 1'b0;
    rx_gaps     = 1'b0;
    hold_reqs   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      program_regs(p);
      if (p == 1) begin
        // keep offering while the receiver holds off so the input stalls
        hold_reqs++;
        repeat (24) push_word(rand_word(FN_PEER_DATA));
      end
      if (p == 2) begin
        // zero timeout and the top retry limit: run out every resend
        push_word(rand_word(FN_USER_BYTE));
        repeat (260) push_word(rand_word(FN_TICK));
      end
      while (words_sent < (p + 1) * WORD_TARGET / PHASES) run_transfer(p == PHASES - 1);
    end
    wait_drained();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
